FILE: src/itsb_pkg.sv
// Shared types, codes and the control store of the interval timer slot bank.
// No dependencies; every other file uses this package by scoped names.
`timescale 1ns / 1ps

package itsb_pkg;

  // Command codes of the input item.
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_REGISTER = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Result kinds.
  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Input and result items.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] time_ms;
    logic [7:0]  handler_id;
    logic [7:0]  interval_ms;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] handler_id_out;
    logic [1:0] status;
    logic       last;
  } out_t;

  // Micro-operations that the datapath carries out.
  typedef enum logic [3:0] {
    U_FETCH,
    U_TCHK,
    U_TSLOT,
    U_TEND,
    U_RSCAN,
    U_RFULL,
    U_RHIT,
    U_CSCAN,
    U_CNF,
    U_CHIT
  } uop_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_DISPATCH,
    C_EL_ZERO,
    C_FREE,
    C_MATCH
  } cond_t;

  typedef logic [3:0] uaddr_t;

  // One control word of the program.
  typedef struct packed {
    uop_t   uop;
    cond_t  cond;
    logic   loop;
    uaddr_t target;
  } ctrl_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic       in_xfer;
    logic [1:0] cmd;
    logic       el_zero;
    logic       free;
    logic       match;
    logic       idx_last;
    logic       hold;
  } flags_t;

  // Program addresses.
  localparam uaddr_t A_FETCH = 4'd0;
  localparam uaddr_t A_TCHK  = 4'd1;
  localparam uaddr_t A_TSLOT = 4'd2;
  localparam uaddr_t A_TEND  = 4'd3;
  localparam uaddr_t A_RSCAN = 4'd4;
  localparam uaddr_t A_RFULL = 4'd5;
  localparam uaddr_t A_RHIT  = 4'd6;
  localparam uaddr_t A_CSCAN = 4'd7;
  localparam uaddr_t A_CNF   = 4'd8;
  localparam uaddr_t A_CHIT  = 4'd9;

  // Control store. A loop step repeats with the slot index advancing until the
  // last slot, then falls through, unless its jump condition is taken first.
  function automatic ctrl_t rom_word(input uaddr_t addr);
    ctrl_t w;
    case (addr)
      A_FETCH: w = '{uop: U_FETCH, cond: C_DISPATCH, loop: 1'b0, target: A_FETCH};
      A_TCHK:  w = '{uop: U_TCHK,  cond: C_EL_ZERO,  loop: 1'b0, target: A_FETCH};
      A_TSLOT: w = '{uop: U_TSLOT, cond: C_NONE,     loop: 1'b1, target: A_TSLOT};
      A_TEND:  w = '{uop: U_TEND,  cond: C_ALWAYS,   loop: 1'b0, target: A_FETCH};
      A_RSCAN: w = '{uop: U_RSCAN, cond: C_FREE,     loop: 1'b1, target: A_RHIT};
      A_RFULL: w = '{uop: U_RFULL, cond: C_ALWAYS,   loop: 1'b0, target: A_FETCH};
      A_RHIT:  w = '{uop: U_RHIT,  cond: C_ALWAYS,   loop: 1'b0, target: A_FETCH};
      A_CSCAN: w = '{uop: U_CSCAN, cond: C_MATCH,    loop: 1'b1, target: A_CHIT};
      A_CNF:   w = '{uop: U_CNF,   cond: C_ALWAYS,   loop: 1'b0, target: A_FETCH};
      A_CHIT:  w = '{uop: U_CHIT,  cond: C_ALWAYS,   loop: 1'b0, target: A_FETCH};
      default: w = '{uop: U_FETCH, cond: C_ALWAYS,   loop: 1'b0, target: A_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: src/itsb_seq.sv
// Microprogram sequencer: step counter, control store lookup and jump logic.
// Depends on itsb_pkg for the control word, flags and program addresses.
`timescale 1ns / 1ps

module itsb_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  itsb_pkg::flags_t flags,
  output itsb_pkg::ctrl_t  ctrl
);

  itsb_pkg::uaddr_t upc_r;
  itsb_pkg::uaddr_t upc_nxt;
  itsb_pkg::uaddr_t seq_addr;

  // Current control word.
  assign ctrl = itsb_pkg::rom_word(upc_r);

  // Repeat a loop step until the last slot, otherwise step forward.
  assign seq_addr = (ctrl.loop && !flags.idx_last) ? upc_r : upc_r + 4'd1;

  // Next address selection.
  always_comb begin
    upc_nxt = seq_addr;
    case (ctrl.cond)
      itsb_pkg::C_NONE:   upc_nxt = seq_addr;
      itsb_pkg::C_ALWAYS: upc_nxt = ctrl.target;
      itsb_pkg::C_DISPATCH: begin
        upc_nxt = itsb_pkg::A_FETCH;
        if (flags.in_xfer) begin
          case (flags.cmd)
            itsb_pkg::CMD_TICK:     upc_nxt = itsb_pkg::A_TCHK;
            itsb_pkg::CMD_REGISTER: upc_nxt = itsb_pkg::A_RSCAN;
            itsb_pkg::CMD_CLEAR:    upc_nxt = itsb_pkg::A_CSCAN;
            default:                upc_nxt = itsb_pkg::A_FETCH;
          endcase
        end
      end
      itsb_pkg::C_EL_ZERO: upc_nxt = flags.el_zero ? ctrl.target : seq_addr;
      itsb_pkg::C_FREE:    upc_nxt = flags.free ? ctrl.target : seq_addr;
      itsb_pkg::C_MATCH:   upc_nxt = flags.match ? ctrl.target : seq_addr;
      default:             upc_nxt = itsb_pkg::A_FETCH;
    endcase
    // A step waiting for the output register stays where it is.
    if (flags.hold) begin
      upc_nxt = upc_r;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= itsb_pkg::A_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // A register command goes straight to the free slot search.
  a_dispatch_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (flags.in_xfer && flags.cmd == itsb_pkg::CMD_REGISTER) |=> upc_r == itsb_pkg::A_RSCAN)
    else $error("register command did not dispatch to the slot search");

  // A stalled step never advances the program.
  a_hold_stays: assert property (@(posedge clk) disable iff (!rst_n)
    flags.hold |=> $stable(upc_r))
    else $error("sequencer moved while a step was held");

endmodule

FILE: src/itsb_dp.sv
// Datapath of the timer slot bank: slot registers, tick arithmetic, pending
// fire event and output register. Driven by control words from itsb_seq.
`timescale 1ns / 1ps

module itsb_dp #(
  parameter int SLOT_COUNT = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  itsb_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output itsb_pkg::out_t   out_data,
  input  itsb_pkg::ctrl_t  ctrl,
  output itsb_pkg::flags_t flags
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);

  // Slot state.
  logic [7:0] period_r  [SLOT_COUNT];
  logic [7:0] count_r   [SLOT_COUNT];
  logic [7:0] handler_r [SLOT_COUNT];

  // Latched item fields and tick state.
  logic [15:0]   time_r;
  logic [7:0]    hid_r;
  logic [7:0]    ivl_r;
  logic [15:0]   last_time_r;
  logic [7:0]    el_r;
  logic [IW-1:0] idx_r;

  // Fire event waiting to learn whether it is the last one of the tick.
  logic       pend_v_r;
  logic [7:0] pend_id_r;

  // Output register.
  logic           out_v_r;
  itsb_pkg::out_t out_r;

  logic           in_xfer;
  logic [15:0]    diff;
  logic [7:0]     cur_period;
  logic [7:0]     cur_count;
  logic [7:0]     cur_handler;
  logic [7:0]     cnt_sum;
  logic           fire;
  logic           room;
  logic           hold;
  logic           emit;
  itsb_pkg::out_t emit_data;

  // Input side: an item is taken only at the fetch step and never during reset.
  assign in_stall = !rst_n || (ctrl.uop != itsb_pkg::U_FETCH);
  assign in_xfer  = in_valid && !in_stall;

  // Slot read at the scan index and the tick arithmetic.
  assign diff        = time_r - last_time_r;
  assign cur_period  = period_r[idx_r];
  assign cur_count   = count_r[idx_r];
  assign cur_handler = handler_r[idx_r];
  assign cnt_sum     = cur_count + el_r;
  assign fire        = (cur_period != 8'd0) && (cnt_sum >= cur_period);
  assign room        = !out_v_r || !out_stall;

  // Result selection and output back-pressure per step.
  always_comb begin
    hold      = 1'b0;
    emit      = 1'b0;
    emit_data = '{kind: itsb_pkg::KIND_STATUS, handler_id_out: 8'd0,
                  status: itsb_pkg::ST_OK, last: 1'b1};
    case (ctrl.uop)
      itsb_pkg::U_TSLOT: begin
        hold      = fire && pend_v_r && !room;
        emit      = fire && pend_v_r && room;
        emit_data = '{kind: itsb_pkg::KIND_FIRE, handler_id_out: pend_id_r,
                      status: itsb_pkg::ST_OK, last: 1'b0};
      end
      itsb_pkg::U_TEND: begin
        hold      = pend_v_r && !room;
        emit      = pend_v_r && room;
        emit_data = '{kind: itsb_pkg::KIND_FIRE, handler_id_out: pend_id_r,
                      status: itsb_pkg::ST_OK, last: 1'b1};
      end
      itsb_pkg::U_RFULL: begin
        hold             = !room;
        emit             = room;
        emit_data.status = itsb_pkg::ST_FULL;
      end
      itsb_pkg::U_CNF: begin
        hold             = !room;
        emit             = room;
        emit_data.status = itsb_pkg::ST_NOT_FOUND;
      end
      itsb_pkg::U_RHIT, itsb_pkg::U_CHIT: begin
        hold = !room;
        emit = room;
      end
      default: begin
        hold = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  // Flags for the sequencer.
  assign flags = '{in_xfer: in_xfer, cmd: in_data.command, el_zero: (diff == 16'd0),
                   free: (cur_period == 8'd0), match: (cur_handler == hid_r),
                   idx_last: (idx_r == IDX_LAST), hold: hold};

  // Output register: loads a result, drops valid after the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Fields of the accepted item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      time_r <= in_data.time_ms;
      hid_r  <= in_data.handler_id;
      ivl_r  <= in_data.interval_ms;
    end
  end

  // Tick time and elapsed time; only the low byte matters for 8-bit counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= 16'd0;
    end else if (ctrl.uop == itsb_pkg::U_TCHK && diff != 16'd0) begin
      last_time_r <= time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop == itsb_pkg::U_TCHK) begin
      el_r <= diff[7:0];
    end
  end

  // Scan index: cleared at fetch, advanced by loop steps that do not branch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (ctrl.uop == itsb_pkg::U_FETCH) begin
      idx_r <= '0;
    end else if (!hold && idx_r != IDX_LAST) begin
      case (ctrl.uop)
        itsb_pkg::U_TSLOT: idx_r <= idx_r + 1'b1;
        itsb_pkg::U_RSCAN: if (cur_period != 8'd0) idx_r <= idx_r + 1'b1;
        itsb_pkg::U_CSCAN: if (cur_handler != hid_r) idx_r <= idx_r + 1'b1;
        default:           idx_r <= idx_r;
      endcase
    end
  end

  // Pending fire event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else begin
      case (ctrl.uop)
        itsb_pkg::U_TCHK:  pend_v_r <= 1'b0;
        itsb_pkg::U_TSLOT: if (fire && !hold) pend_v_r <= 1'b1;
        itsb_pkg::U_TEND:  if (!hold) pend_v_r <= 1'b0;
        default:           pend_v_r <= pend_v_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.uop == itsb_pkg::U_TSLOT && fire && !hold) begin
      pend_id_r <= cur_handler;
    end
  end

  // Slot updates at the scan index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        period_r[i]  <= 8'd0;
        count_r[i]   <= 8'd0;
        handler_r[i] <= 8'd0;
      end
    end else if (!hold) begin
      case (ctrl.uop)
        itsb_pkg::U_TSLOT: begin
          if (cur_period != 8'd0) begin
            count_r[idx_r] <= fire ? 8'd0 : cnt_sum;
          end
        end
        itsb_pkg::U_RHIT: begin
          period_r[idx_r]  <= ivl_r;
          count_r[idx_r]   <= 8'd0;
          handler_r[idx_r] <= hid_r;
        end
        itsb_pkg::U_CHIT: begin
          period_r[idx_r]  <= 8'd0;
          handler_r[idx_r] <= 8'd0;
        end
        default: begin
          period_r[idx_r] <= period_r[idx_r];
        end
      endcase
    end
  end

  // No fire event is left over once the program is back at fetch.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.uop == itsb_pkg::U_FETCH) |-> !pend_v_r)
    else $error("pending fire event left at fetch");

  // Every item starts its scan at the first slot.
  a_idx_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> idx_r == '0)
    else $error("scan index not cleared for a new item");

  // A fire event blocked by a full output keeps the pending one intact.
  a_pend_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.uop == itsb_pkg::U_TSLOT && hold) |=> pend_v_r && $stable(pend_id_r))
    else $error("pending fire event lost while held");

endmodule

FILE: src/interval_timer_slot_bank_unit.sv
// Interval timer slot bank: a bank of periodic timer slots run by a
// microprogrammed sequencer over a slot datapath.
// Depends on itsb_pkg, itsb_seq and itsb_dp.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one command per
//   transfer: tick with the current millisecond time, register a handler with
//   a period, or clear a handler. The result channel (out_valid, out_stall,
//   out_data) returns one status per register or clear, and one fire event
//   per expiring slot on a tick, the final one of each item flagged by last.
//   A tick with no elapsed time and an undefined command give no result.
//   Timing: an item takes a fetch step, then walks the slots one per
//   cycle through the shared datapath unless a step is held for the output
//   register. A tick with no elapsed time skips the scan; register and clear
//   stop where the search stops. The slot scan sets the rate: a new item is
//   taken only at the fetch step. A status is valid in the cycle after the
//   step that makes it; a fire event waits for the next firing slot or the
//   scan end so its last flag is known, and is valid in the cycle after that.
//   While the receiver stalls, the output register holds its result; the
//   scan continues until it has a further result to deliver, then waits.
//   Reset frees every slot, clears all counts and handler ids and sets the
//   last tick time to zero; in_stall stays high until reset is released.
`timescale 1ns / 1ps

module interval_timer_slot_bank_unit #(
  parameter int SLOT_COUNT = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  itsb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output itsb_pkg::out_t out_data
);

  itsb_pkg::ctrl_t  ctrl;
  itsb_pkg::flags_t flags;

  // Program sequencer.
  itsb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Slot datapath and channel registers.
  itsb_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctrl      (ctrl),
    .flags     (flags)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the interval timer slot bank.
// Depends on itsb_pkg and interval_timer_slot_bank_unit; a local mirror of the
// slot bank predicts every fire event and status that the block must return.
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS = 8;
  localparam int RANDOM_CMDS = 200;
  // Command value that the block must ignore.
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;

  // A queued command, optionally held back until the bank has gone quiet.
  typedef struct {
    itsb_pkg::in_t item;
    bit            drain_first;
  } pending_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  itsb_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  itsb_pkg::out_t out_data;

  // Mirror of the slot bank.
  logic [7:0]  period_mirror [SLOTS];
  logic [7:0]  count_mirror [SLOTS];
  logic [7:0]  owner_mirror [SLOTS];
  logic [15:0] tick_stamp;

  pending_t       cmd_backlog[$];
  itsb_pkg::out_t due_results[$];
  int             mismatch_count = 0;

  // Generator bookkeeping.
  logic [15:0] gen_stamp = '0;
  int          counted_cmds = 0;

  // Sender and receiver pacing.
  bit             in_taken = 1'b0;
  bit             send_now;
  bit             stall_next;
  pending_t       next_cmd;
  int             burst_left = 5;
  int             gap_left = 0;
  int             rx_hold = 0;
  int             rx_run = 30;
  itsb_pkg::out_t got;
  itsb_pkg::out_t want;

  interval_timer_slot_bank_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one accepted command to the mirror and queues the results it causes.
  task automatic advance_timer_bank(input itsb_pkg::in_t cmd);
    logic [15:0] elapsed;
    logic [SLOTS-1:0] fired;
    itsb_pkg::out_t ev;
    bit done;
    elapsed = cmd.time_ms - tick_stamp;
    fired = '0;
    done = 1'b0;
    ev = '0;
    case (cmd.command)
      itsb_pkg::CMD_TICK: begin
        if (elapsed != 16'd0) begin
          tick_stamp = cmd.time_ms;
          for (int i = 0; i < SLOTS; i++) begin
            if (period_mirror[i] != 8'd0) begin
              count_mirror[i] = count_mirror[i] + elapsed[7:0];
              if (count_mirror[i] >= period_mirror[i]) begin
                count_mirror[i] = 8'd0;
                fired[i] = 1'b1;
              end
            end
          end
          // Fire events leave in slot order; the highest firing slot closes the item.
          for (int i = 0; i < SLOTS; i++) begin
            if (fired[i]) begin
              ev.kind = itsb_pkg::KIND_FIRE;
              ev.handler_id_out = owner_mirror[i];
              ev.status = itsb_pkg::ST_OK;
              ev.last = ((fired >> (i + 1)) == '0);
              due_results.push_back(ev);
            end
          end
        end
      end
      itsb_pkg::CMD_REGISTER: begin
        ev.kind = itsb_pkg::KIND_STATUS;
        ev.status = itsb_pkg::ST_FULL;
        ev.last = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && period_mirror[i] == 8'd0) begin
            owner_mirror[i] = cmd.handler_id;
            period_mirror[i] = cmd.interval_ms;
            count_mirror[i] = 8'd0;
            ev.status = itsb_pkg::ST_OK;
            done = 1'b1;
          end
        end
        due_results.push_back(ev);
      end
      itsb_pkg::CMD_CLEAR: begin
        ev.kind = itsb_pkg::KIND_STATUS;
        ev.status = itsb_pkg::ST_NOT_FOUND;
        ev.last = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && owner_mirror[i] == cmd.handler_id) begin
            period_mirror[i] = 8'd0;
            owner_mirror[i] = 8'd0;
            ev.status = itsb_pkg::ST_OK;
            done = 1'b1;
          end
        end
        due_results.push_back(ev);
      end
      default: begin
        // An undefined command leaves the bank untouched.
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  task automatic queue_cmd(input logic [1:0] op, input logic [15:0] t,
                           input logic [7:0] id, input logic [7:0] per, input bit drain);
    pending_t p;
    p.item = '{command: op, time_ms: t, handler_id: id, interval_ms: per};
    p.drain_first = drain;
    cmd_backlog.push_back(p);
    // Ignored commands do not count toward the stimulus length.
    if (op == itsb_pkg::CMD_REGISTER || op == itsb_pkg::CMD_CLEAR ||
        (op == itsb_pkg::CMD_TICK && t != gen_stamp)) begin
      counted_cmds++;
    end
    if (op == itsb_pkg::CMD_TICK) begin
      gen_stamp = t;
    end
  endtask

  // Input driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    send_now = 1'b0;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0 &&
                   !(cmd_backlog[0].drain_first && due_results.size() > 0)) begin
        next_cmd = cmd_backlog.pop_front();
        send_now = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
                       $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid <= send_now;
      if (send_now) begin
        in_data <= next_cmd.item;
      end
    end
  end

  // Receiver stall pattern: stall spells alternating with free-running stretches.
  always @(negedge clk) begin
    stall_next = 1'b0;
    if (rx_hold > 0) begin
      rx_hold--;
      stall_next = 1'b1;
    end else if (rx_run > 0) begin
      rx_run--;
    end else begin
      rx_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
      rx_hold = $urandom_range(1, 10);
    end
    out_stall <= stall_next;
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      advance_timer_bank(in_data);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (due_results.size() == 0) begin
        $display("%0t ns: expected no result, got kind %0d id %0d status %0d last %0d",
                 $time, got.kind, got.handler_id_out, got.status, got.last);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(got.kind));
        check_field("handler_id_out", 16'(want.handler_id_out), 16'(got.handler_id_out));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("last", 16'(want.last), 16'(got.last));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    logic [7:0] id;
    logic [7:0] per;
    logic [15:0] step;
    for (int i = 0; i < SLOTS; i++) begin
      period_mirror[i] = 8'd0;
      count_mirror[i] = 8'd0;
      owner_mirror[i] = 8'd0;
    end
    tick_stamp = 16'd0;

    // Directed part. A tick at the reset time has no elapsed time.
    queue_cmd(itsb_pkg::CMD_TICK, 16'h0000, 8'hff, 8'hff, 1'b0);
    // Clearing id zero hits a slot never written since reset.
    queue_cmd(itsb_pkg::CMD_CLEAR, 16'hffff, 8'h00, 8'h00, 1'b0);
    queue_cmd(itsb_pkg::CMD_REGISTER, 16'hffff, 8'hff, 8'h01, 1'b0);
    queue_cmd(itsb_pkg::CMD_REGISTER, 16'h0000, 8'h01, 8'hff, 1'b0);
    // A zero period writes the id but leaves the slot free for the next register.
    queue_cmd(itsb_pkg::CMD_REGISTER, 16'h1234, 8'h07, 8'h00, 1'b0);
    queue_cmd(itsb_pkg::CMD_REGISTER, 16'h8000, 8'h08, 8'h03, 1'b0);
    queue_cmd(CMD_UNDEFINED, 16'hffff, 8'hff, 8'hff, 1'b0);
    // Largest elapsed time makes every registered slot fire.
    queue_cmd(itsb_pkg::CMD_TICK, 16'hffff, 8'h00, 8'h00, 1'b0);
    queue_cmd(itsb_pkg::CMD_TICK, 16'hffff, 8'h55, 8'haa, 1'b0);
    // Time wraps back to zero: one millisecond elapsed.
    queue_cmd(itsb_pkg::CMD_TICK, 16'h0000, 8'haa, 8'h55, 1'b0);
    for (int k = 0; k < 6; k++) begin
      queue_cmd(itsb_pkg::CMD_REGISTER, 16'($urandom), 8'(20 + k), 8'(2 + k), 1'b0);
    end
    queue_cmd(itsb_pkg::CMD_CLEAR, 16'h0f0f, 8'd200, 8'h00, 1'b1);
    queue_cmd(itsb_pkg::CMD_CLEAR, 16'hf0f0, 8'h00, 8'h00, 1'b0);
    queue_cmd(itsb_pkg::CMD_CLEAR, 16'h0000, 8'hff, 8'h00, 1'b0);
    queue_cmd(itsb_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00, 1'b0);
    queue_cmd(itsb_pkg::CMD_TICK, 16'h0005, 8'h00, 8'h00, 1'b0);

    // Random part: mostly register, clear and small ticks over a small id pool.
    r = counted_cmds + RANDOM_CMDS;
    while (counted_cmds < r) begin
      id = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) :
           8'($urandom_range(1, 10));
      case ($urandom_range(0, 99)) inside
        [0:39]:  step = 16'($urandom_range(1, 12));
        [40:43]: step = 16'($urandom_range(13, 600));
        [44:45]: step = 16'($urandom);
        [46:47]: step = 16'd0;
        default: step = 16'hffff;
      endcase
      per = ($urandom_range(0, 9) == 0) ? 8'd0 :
            ($urandom_range(0, 7) == 0) ? 8'($urandom_range(25, 255)) :
            8'($urandom_range(1, 24));
      case ($urandom_range(0, 99)) inside
        [0:47]: begin
          if (step == 16'hffff) step = 16'($urandom_range(1, 12));
          queue_cmd(itsb_pkg::CMD_TICK, gen_stamp + step, 8'($urandom), 8'($urandom),
                    $urandom_range(0, 49) == 0);
        end
        [48:73]: queue_cmd(itsb_pkg::CMD_REGISTER, 16'($urandom), id, per,
                           $urandom_range(0, 49) == 0);
        [74:95]: queue_cmd(itsb_pkg::CMD_CLEAR, 16'($urandom), id, 8'($urandom),
                           $urandom_range(0, 49) == 0);
        default: queue_cmd(CMD_UNDEFINED, 16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      endcase
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    // Let a stray late result show up before the verdict.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
